FILE: rtl/move_to_front_search_list_assert.svh
// assertion macros for the move-to-front list
`ifndef MOVE_TO_FRONT_SEARCH_LIST_ASSERT_SVH
`define MOVE_TO_FRONT_SEARCH_LIST_ASSERT_SVH

// condition implies consequence in the same cycle
`define MTF_ASSERT_SAME(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("move_to_front_search_list: same-cycle check failed");

// condition implies consequence in the next cycle
`define MTF_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("move_to_front_search_list: next-cycle check failed");

`endif

FILE: rtl/mtf_pkg.sv
// shared constants and types for the move-to-front list
`default_nettype none

package mtf_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int VALUE_W     = 32;
    localparam int HIT_POS_W   = 4;
    localparam int ENTRY_CNT_W = 5;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic               cmp_en;
        logic [VALUE_W-1:0] cmp_value;
        logic               upd_en;
        logic               upd_insert;
        logic               upd_found;
    } mtf_ctrl_t;

    // neighbor handoff between adjacent cells
    typedef struct packed {
        logic               hit_seen;
        logic [VALUE_W-1:0] data;
    } mtf_link_t;

endpackage

`default_nettype wire

FILE: rtl/mtf_if.sv
// request and response channel interfaces
`default_nettype none

interface mtf_req_if import mtf_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface mtf_rsp_if import mtf_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic                   found;
    logic [HIT_POS_W-1:0]   hit_position;
    logic                   tail_dropped;
    logic [ENTRY_CNT_W-1:0] entry_count;

    modport source (output valid, output found, output hit_position,
                    output tail_dropped, output entry_count, input ready);
    modport sink   (input valid, input found, input hit_position,
                    input tail_dropped, input entry_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/mtf_cell.sv
// one list cell: holds an entry, compares it, shifts from its left neighbor
`default_nettype none

module mtf_cell import mtf_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mtf_ctrl_t        ctrl,
    input  wire logic [CNT_W-1:0] count,
    input  wire mtf_link_t        link_in,
    output mtf_link_t             link_out,
    output logic                  first_hit
);

    logic [VALUE_W-1:0] data_reg;
    logic [VALUE_W-1:0] data_next;
    logic               match_reg;
    logic               match_next;
    logic               live;
    logic               shift;

    // entry holds a value when it sits below the fill count
    assign live = (count > CNT_W'(INDEX));

    // compare phase
    always_comb
    begin
        match_next = match_reg;
        if (ctrl.cmp_en)
        begin
            match_next = live && (data_reg == ctrl.cmp_value);
        end
    end

    // on insert every cell takes its left neighbor's entry; on a search hit, cells up to the first hit do
    assign shift = ctrl.upd_en &&
                   (ctrl.upd_insert || (ctrl.upd_found && !link_in.hit_seen));

    always_comb
    begin
        data_next = data_reg;
        if (shift)
        begin
            data_next = link_in.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    // entry storage, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // handoff to the right neighbor
    assign link_out.hit_seen = link_in.hit_seen | match_reg;
    assign link_out.data     = data_reg;
    assign first_hit         = match_reg & ~link_in.hit_seen;

endmodule

`default_nettype wire

FILE: rtl/move_to_front_search_list.sv
// Bounded move-to-front list built from a row of compare-and-shift cells.
//
// Channels: req carries req_type (insert or search) and a 32-bit value;
// rsp returns found, hit_position, tail_dropped and entry_count, one word
// per request word. A word is taken when valid and ready are both high.
// Each request has an accept cycle and an update cycle. In the accept
// cycle every cell compares its entry with the value and registers the
// match; in the update cycle, once the output register is free, the
// first-hit chain through the cells picks the hit and the cells shift in
// one step, while the result word is loaded into the output register.
// The next request waits for the update; the result is valid on rsp the
// cycle after the update cycle. The ripple of the first-hit chain across
// the row of DEPTH cells sets the length of the update cycle. The output
// register lets a new request be taken while a result waits; if rsp stays
// stalled, the update waits with it and req stays not ready. Reset empties
// the list (fill count zero); storage is not cleared, only read below it.
`default_nettype none

module move_to_front_search_list import mtf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mtf_req_if.sink    req,
    mtf_rsp_if.source  rsp
);

`include "move_to_front_search_list_assert.svh"

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = (IDX_W > HIT_POS_W) ? IDX_W : HIT_POS_W;
    localparam int CW_W  = (CNT_W > ENTRY_CNT_W) ? CNT_W : ENTRY_CNT_W;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_APPLY = 1'b1;

    logic               state_reg;
    logic               state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               req_type_reg;
    logic [VALUE_W-1:0] value_reg;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_found_reg;
    logic [HIT_POS_W-1:0]   out_pos_reg;
    logic                   out_dropped_reg;
    logic [ENTRY_CNT_W-1:0] out_count_reg;

    logic        accept;
    logic        out_free;
    logic        apply;
    logic        is_insert;
    logic        full;
    logic        found;
    logic [IDX_W-1:0] hit_idx;
    logic [POS_W-1:0] pos_wide;
    logic [CW_W-1:0]  count_wide;

    mtf_ctrl_t       ctrl;
    mtf_link_t       link [DEPTH+1];
    logic [DEPTH-1:0] first_hit;

    // handshake
    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || rsp.ready;
    assign apply    = (state_reg == ST_APPLY) && out_free;

    assign is_insert = (req_type_reg == REQ_INSERT);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign found     = !is_insert && link[DEPTH].hit_seen;

    // broadcast control
    always_comb
    begin
        ctrl.cmp_en     = accept;
        ctrl.cmp_value  = req.value;
        ctrl.upd_en     = apply;
        ctrl.upd_insert = is_insert;
        ctrl.upd_found  = found;
    end

    // front of the chain feeds the request value
    assign link[0].hit_seen = 1'b0;
    assign link[0].data     = value_reg;

    // row of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        mtf_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .count     (count_reg),
            .link_in   (link[i]),
            .link_out  (link[i+1]),
            .first_hit (first_hit[i])
        );
    end

    // encode the one-hot first hit
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (first_hit[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    // sequencer and fill count
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (apply)
                begin
                    state_next = ST_IDLE;
                    if (is_insert && !full)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign pos_wide   = found ? POS_W'(hit_idx) : '0;
    assign count_wide = CW_W'(count_next);

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (apply)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg <= req.req_type;
            value_reg    <= req.value;
        end
        if (apply)
        begin
            out_found_reg   <= found;
            out_pos_reg     <= pos_wide[HIT_POS_W-1:0];
            out_dropped_reg <= is_insert && full;
            out_count_reg   <= count_wide[ENTRY_CNT_W-1:0];
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.found        = out_found_reg;
    assign rsp.hit_position = out_pos_reg;
    assign rsp.tail_dropped = out_dropped_reg;
    assign rsp.entry_count  = out_count_reg;

    // checks
    `MTF_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))
    `MTF_ASSERT_SAME(a_single_hit, state_reg == ST_APPLY, $onehot0(first_hit))
    `MTF_ASSERT_NEXT(a_accept_apply, accept, state_reg == ST_APPLY)
    `MTF_ASSERT_SAME(a_hit_no_drop, apply && found, !(is_insert && full))

endmodule

`default_nettype wire

FILE: bench/mtf_list_checker.sv
// scoreboard for the move-to-front list: mirrors the list and checks every result word
`timescale 1ns / 100ps
`default_nettype none

module mtf_list_checker import mtf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    input  wire logic                   req_ready,
    input  wire logic                   req_type,
    input  wire logic [VALUE_W-1:0]     req_value,
    input  wire logic                   rsp_valid,
    input  wire logic                   rsp_ready,
    input  wire logic                   rsp_found,
    input  wire logic [HIT_POS_W-1:0]   rsp_hit_position,
    input  wire logic                   rsp_tail_dropped,
    input  wire logic [ENTRY_CNT_W-1:0] rsp_entry_count,
    output int                          failures,
    output int                          pending
);

    typedef struct packed {
        logic                   found;
        logic [HIT_POS_W-1:0]   hit_position;
        logic                   tail_dropped;
        logic [ENTRY_CNT_W-1:0] entry_count;
    } mtf_result_t;

    // mirrored list, front at index 0, and its fill level
    logic [VALUE_W-1:0] list_mirror [DEPTH];
    int                 fill_level;
    mtf_result_t        result_queue [$];

    // apply one request to the mirror and return the word it should produce
    function automatic mtf_result_t apply_request(input logic kind,
                                                  input logic [VALUE_W-1:0] v);
        mtf_result_t r;
        int          pos;
        int          i;
        r   = '0;
        pos = -1;
        if (kind == REQ_INSERT) begin
            // a full list drops its tail, otherwise it grows by one
            if (fill_level == DEPTH)
                r.tail_dropped = 1'b1;
            else
                fill_level++;
            for (i = fill_level - 1; i > 0; i--)
                list_mirror[i] = list_mirror[i - 1];
            list_mirror[0] = v;
        end
        else begin
            // first match from the front wins
            for (i = 0; i < fill_level; i++)
                if (pos < 0 && list_mirror[i] == v)
                    pos = i;
            if (pos >= 0) begin
                r.found        = 1'b1;
                r.hit_position = pos[HIT_POS_W-1:0];
                for (i = pos; i > 0; i--)
                    list_mirror[i] = list_mirror[i - 1];
                list_mirror[0] = v;
            end
        end
        r.entry_count = fill_level[ENTRY_CNT_W-1:0];
        return r;
    endfunction

    task automatic compare_field(input string name, input int want, input int got,
                                 input logic bad);
        if (bad) begin
            $error("field %s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endtask

    // responses are checked before requests are logged, so the oldest word matches
    always @(posedge clk or negedge rst_n)
    begin
        mtf_result_t want;
        if (!rst_n) begin
            fill_level = 0;
            result_queue.delete();
            failures = 0;
            pending  = 0;
        end
        else begin
            if (rsp_valid && rsp_ready) begin
                if (result_queue.size() == 0) begin
                    $error("result word with no request outstanding");
                    failures++;
                end
                else begin
                    want = result_queue.pop_front();
                    compare_field("found", int'(want.found), int'(rsp_found),
                                  rsp_found !== want.found);
                    compare_field("hit_position", int'(want.hit_position),
                                  int'(rsp_hit_position),
                                  rsp_hit_position !== want.hit_position);
                    compare_field("tail_dropped", int'(want.tail_dropped),
                                  int'(rsp_tail_dropped),
                                  rsp_tail_dropped !== want.tail_dropped);
                    compare_field("entry_count", int'(want.entry_count),
                                  int'(rsp_entry_count),
                                  rsp_entry_count !== want.entry_count);
                end
            end
            if (req_valid && req_ready)
                result_queue.push_back(apply_request(req_type, req_value));
            pending = result_queue.size();
        end
    end

endmodule

`default_nettype wire

FILE: bench/tb_move_to_front_search_list.sv
// top of the move-to-front list bench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
`default_nettype none

module tb_move_to_front_search_list;
    import mtf_pkg::*;

    localparam int CLK_HALF   = 4;
    localparam int ITEMS      = 1950;
    localparam int POOL_SIZE  = 24;
    localparam int HOLD_LEN   = 64;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    int   tx_idle_pct = 33;
    int   rx_idle_pct = 49;
    logic hold_request = 1'b0;
    int   failures;
    int   pending;

    logic [VALUE_W-1:0] value_pool [POOL_SIZE];

    mtf_req_if req ();
    mtf_rsp_if rsp ();

    move_to_front_search_list #(.DEPTH(DEPTH_DEF)) uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    mtf_list_checker #(.DEPTH(DEPTH_DEF)) checker_i
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req.valid),
        .req_ready        (req.ready),
        .req_type         (req.req_type),
        .req_value        (req.value),
        .rsp_valid        (rsp.valid),
        .rsp_ready        (rsp.ready),
        .rsp_found        (rsp.found),
        .rsp_hit_position (rsp.hit_position),
        .rsp_tail_dropped (rsp.tail_dropped),
        .rsp_entry_count  (rsp.entry_count),
        .failures         (failures),
        .pending          (pending)
    );

    always #(CLK_HALF) clk = ~clk;

    // offer one request word, with random idle cycles ahead of it
    task automatic send_word(input logic kind, input logic [VALUE_W-1:0] v);
        while ($urandom_range(99) < tx_idle_pct) begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid    <= 1'b1;
        req.req_type <= kind;
        req.value    <= v;
        // ready holds from the falling edge, so it tells whether the next rising edge takes the word
        while (!req.ready)
            @(negedge clk);
        @(negedge clk);
    endtask

    // mostly pool values so searches hit, with extremes and raw random bits
    function automatic logic [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return value_pool[$urandom_range(POOL_SIZE - 1)];
        else if (roll < 80)
            case ($urandom_range(3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        return $urandom();
    endfunction

    task automatic random_words(input int count);
        int n;
        for (n = 0; n < count; n++)
            send_word(($urandom_range(99) < 40) ? REQ_INSERT : REQ_SEARCH, pick_value());
    endtask

    // response side: random back-pressure plus one long hold-off on request
    initial
    begin : rsp_drive
        int stall_left;
        bit hold_taken;
        stall_left = 0;
        hold_taken = 0;
        rsp.ready  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request && !hold_taken) begin
                stall_left = HOLD_LEN;
                hold_taken = 1;
            end
            if (stall_left > 0) begin
                rsp.ready <= 1'b0;
                stall_left--;
            end
            else
                rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // run limit
    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        req.valid    = 1'b0;
        req.req_type = REQ_INSERT;
        req.value    = '0;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'hFFFF_FFFF;
        value_pool[3] = 32'h0000_0000;
        for (i = 4; i < POOL_SIZE; i++)
            value_pool[i] = $urandom();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty search, front hit, extremes, duplicates, full list
        send_word(REQ_SEARCH, 32'h0000_0000);
        send_word(REQ_INSERT, 32'h0000_0000);
        send_word(REQ_SEARCH, 32'h0000_0000);
        send_word(REQ_INSERT, 32'h8000_0000);
        send_word(REQ_INSERT, 32'h7FFF_FFFF);
        send_word(REQ_INSERT, 32'hFFFF_FFFF);
        send_word(REQ_INSERT, 32'h0000_0001);
        send_word(REQ_SEARCH, 32'h0000_0000);
        send_word(REQ_SEARCH, 32'h0000_0000);
        send_word(REQ_SEARCH, 32'h0000_3039);
        send_word(REQ_INSERT, 32'h0000_0005);
        send_word(REQ_INSERT, 32'h0000_0007);
        send_word(REQ_INSERT, 32'h0000_0005);
        send_word(REQ_SEARCH, 32'h0000_0005);
        send_word(REQ_SEARCH, 32'h0000_0007);
        for (i = 0; i < 9; i++)
            send_word(REQ_INSERT, 32'h0000_0064 + i);
        send_word(REQ_SEARCH, 32'h0000_0064);

        // first random phase, then drain completely before changing pace
        random_words(ITEMS / 3);
        req.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);

        tx_idle_pct = 49;
        rx_idle_pct = 33;
        random_words(ITEMS / 3);

        // full rate, with a long receiver hold-off in the middle
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_words(ITEMS / 6);
        hold_request = 1'b1;
        random_words(ITEMS / 3 - ITEMS / 6);

        req.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
